FILE: rtl/sti_pkg.sv
// Shared types and constants of the sorted key/value table.
// Holds field widths, operation and status codes, and the controller/datapath structs.
// No dependencies.
package sti_pkg;

  // Defaults for the top-level parameters.
  localparam int CAPACITY_DEF  = 256;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed field widths of the request and response channels.
  localparam int ACTION_W = 3;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 9;
  localparam int COUNT_W  = 9;

  // Configuration port widths.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register word indexes, decoded from paddr[APB_AW-1:2].
  localparam logic [APB_AW-3:0] REG_ALLOW_DUP = '0;

  // Operation codes.
  localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SEARCH   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REM_KEY  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REM_IDX  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ_IDX = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STS_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] STS_MISS = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                latch;         // capture the request operands
    logic                idx_read;      // read the slot named by the request index
    logic                bs_read;       // read the midpoint of the search window
    logic                bs_update;     // narrow the search window
    logic                probe_read;    // read the slot at the lower bound
    logic                probe_capture; // evaluate the match at the lower bound
    logic                idx_capture;   // take key and value of the indexed slot
    logic                clr_key;       // zero the returned key
    logic                set_status;    // load the status code below
    logic [STATUS_W-1:0] status;
    logic                up_start;      // begin the upward shift at the last entry
    logic                up_step;       // move one entry up, read the next lower one
    logic                write_new;     // write the new entry at the insertion point
    logic                dn_start;      // begin the downward shift above the slot
    logic                dn_step;       // move one entry down, read the next higher one
    logic                cnt_inc;
    logic                cnt_dec;
    logic                cnt_clear;
    logic                load_out;      // move the result into the output register
  } sti_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACTION_W-1:0] req_action;  // action of the request on the input channel
    logic                req_idx_ok;  // request index lies below the entry count
    logic [ACTION_W-1:0] action;      // action of the item in progress
    logic                lo_lt_hi;
    logic                lo_lt_cnt;
    logic                lo1_lt_cnt;
    logic                hit;
    logic                full;
    logic                ptr_gt_lo;
    logic                ptr1_lt_cnt;
    logic                out_free;
  } sti_sts_t;

endpackage

FILE: rtl/sti_if.sv
// Valid/ready channel interfaces for the request and response streams.
// Depends on sti_pkg for the field widths.
interface sti_in_if
  import sti_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DATA_W-1:0]   key;
  logic [DATA_W-1:0]   value;
  logic [INDEX_W-1:0]  index;

  modport source (output valid, action, key, value, index, input ready);
  modport sink   (input valid, action, key, value, index, output ready);
endinterface

interface sti_out_if
  import sti_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [POS_W-1:0]    position;
  logic [DATA_W-1:0]   key_out;
  logic [DATA_W-1:0]   value_out;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, status, found, position, key_out, value_out, count,
                  input ready);
  modport sink   (input valid, status, found, position, key_out, value_out, count,
                  output ready);
endinterface

FILE: rtl/sti_ctrl.sv
// Sequencer of the sorted table: binary search, shifts and result hand-off.
// Depends on sti_pkg for the command and status structs and the codes.
module sti_ctrl
  import sti_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     allow_dup_i,
  input  sti_sts_t sts_i,
  output sti_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_CMP    = 4'd2;
  localparam logic [3:0] S_PROBE  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_IDXW   = 4'd5;
  localparam logic [3:0] S_UP     = 4'd6;
  localparam logic [3:0] S_NEW    = 4'd7;
  localparam logic [3:0] S_DN     = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          if (sts_i.req_action inside {ACT_INSERT, ACT_SEARCH, ACT_REM_KEY}) begin
            state_d = S_CHECK;
          end else if (sts_i.req_action inside {ACT_REM_IDX, ACT_READ_IDX}) begin
            if (sts_i.req_idx_ok) begin
              cmd_o.idx_read = 1'b1;
              state_d        = S_IDXW;
            end else begin
              state_d = S_FINISH;
            end
          end else if (sts_i.req_action == ACT_CLEAR) begin
            cmd_o.cnt_clear = 1'b1;
            state_d         = S_FINISH;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_CHECK: begin
        // Halve the window until it is empty, then look at the lower bound.
        if (sts_i.lo_lt_hi) begin
          cmd_o.bs_read = 1'b1;
          state_d       = S_CMP;
        end else begin
          cmd_o.probe_read = 1'b1;
          state_d          = S_PROBE;
        end
      end
      S_CMP: begin
        cmd_o.bs_update = 1'b1;
        state_d         = S_CHECK;
      end
      S_PROBE: begin
        cmd_o.probe_capture = 1'b1;
        state_d             = S_DECIDE;
      end
      S_DECIDE: begin
        case (sts_i.action)
          ACT_INSERT: begin
            cmd_o.clr_key = 1'b1;
            if (sts_i.hit && !allow_dup_i) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_DUP;
              state_d          = S_FINISH;
            end else if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_FULL;
              state_d          = S_FINISH;
            end else if (sts_i.lo_lt_cnt) begin
              cmd_o.up_start = 1'b1;
              state_d        = S_UP;
            end else begin
              state_d = S_NEW;
            end
          end
          ACT_SEARCH: begin
            cmd_o.clr_key = 1'b1;
            if (sts_i.hit) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_OK;
            end
            state_d = S_FINISH;
          end
          ACT_REM_KEY: begin
            if (sts_i.hit) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_OK;
              if (sts_i.lo1_lt_cnt) begin
                cmd_o.dn_start = 1'b1;
                state_d        = S_DN;
              end else begin
                cmd_o.cnt_dec = 1'b1;
                state_d       = S_FINISH;
              end
            end else begin
              state_d = S_FINISH;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_IDXW: begin
        cmd_o.idx_capture = 1'b1;
        cmd_o.set_status  = 1'b1;
        cmd_o.status      = STS_OK;
        if (sts_i.action == ACT_REM_IDX) begin
          if (sts_i.lo1_lt_cnt) begin
            cmd_o.dn_start = 1'b1;
            state_d        = S_DN;
          end else begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_FINISH;
          end
        end else begin
          state_d = S_FINISH;
        end
      end
      S_UP: begin
        cmd_o.up_step = 1'b1;
        if (!sts_i.ptr_gt_lo) begin
          state_d = S_NEW;
        end
      end
      S_NEW: begin
        cmd_o.write_new  = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = STS_OK;
        state_d          = S_FINISH;
      end
      S_DN: begin
        cmd_o.dn_step = 1'b1;
        if (!sts_i.ptr1_lt_cnt) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_FINISH: begin
        // Wait until the output register can take the result.
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is only handed over when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result loaded while output register is occupied");

  // A new entry is never written into a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NEW) |-> !sts_i.full)
    else $error("insert into a full table");

  // The upward shift only runs while the insertion point lies inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP) |-> sts_i.lo_lt_cnt)
    else $error("upward shift with insertion point at the end");

endmodule

FILE: rtl/sti_dpath.sv
// Datapath of the sorted table: entry memory, search window, shift pointer,
// entry count, result fields and output register. Depends on sti_pkg and sti_out_if.
module sti_dpath
  import sti_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ACTION_W-1:0] req_action_i,
  input  logic [DATA_W-1:0]   req_key_i,
  input  logic [DATA_W-1:0]   req_value_i,
  input  logic [INDEX_W-1:0]  req_index_i,
  input  sti_cmd_t            cmd_i,
  output sti_sts_t            sts_o,
  sti_out_if.source           rsp_o
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Entry memory: one write port, one registered read port.
  logic [KEY_WIDTH-1:0] key_mem [CAPACITY];
  logic [DATA_W-1:0]    val_mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rd_key_q;
  logic [DATA_W-1:0]    rd_val_q;

  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0] wr_key;
  logic [DATA_W-1:0]    wr_val;

  // Operands of the item in progress.
  logic [ACTION_W-1:0]  act_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [DATA_W-1:0]    val_q;

  // Search window, shift pointer and entry count.
  logic [CNT_W-1:0] lo_q, hi_q, ptr_q, cnt_q;
  logic [CNT_W-1:0] mid, lo_inc, ptr_inc, ptr_dec, cnt_less;
  logic             hit_q, hit;

  // Working result fields.
  logic [STATUS_W-1:0] status_q;
  logic                found_q;
  logic [POS_W-1:0]    pos_q;
  logic [DATA_W-1:0]   kout_q, vout_q;

  // Output register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] o_status_q;
  logic                o_found_q;
  logic [POS_W-1:0]    o_pos_q;
  logic [DATA_W-1:0]   o_kout_q, o_vout_q;
  logic [COUNT_W-1:0]  o_count_q;

  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_inc   = lo_q + 1'b1;
  assign ptr_inc  = ptr_q + 1'b1;
  assign ptr_dec  = ptr_q - 1'b1;
  assign cnt_less = cnt_q - 1'b1;
  assign hit      = (lo_q < cnt_q) && (rd_key_q == key_q);

  // Status toward the controller.
  always_comb begin
    sts_o.req_action  = req_action_i;
    sts_o.req_idx_ok  = 32'(req_index_i) < 32'(cnt_q);
    sts_o.action      = act_q;
    sts_o.lo_lt_hi    = lo_q < hi_q;
    sts_o.lo_lt_cnt   = lo_q < cnt_q;
    sts_o.lo1_lt_cnt  = lo_inc < cnt_q;
    sts_o.hit         = hit_q;
    sts_o.full        = cnt_q == CNT_W'(CAPACITY);
    sts_o.ptr_gt_lo   = ptr_q > lo_q;
    sts_o.ptr1_lt_cnt = ptr_inc < cnt_q;
    sts_o.out_free    = !out_valid_q || rsp_o.ready;
  end

  // Memory address and data selection.
  always_comb begin
    rd_en   = cmd_i.idx_read | cmd_i.bs_read | cmd_i.probe_read | cmd_i.up_start |
              cmd_i.up_step | cmd_i.dn_start | cmd_i.dn_step;
    rd_addr = AW'(lo_q);
    if (cmd_i.idx_read) begin
      rd_addr = AW'(req_index_i);
    end else if (cmd_i.bs_read) begin
      rd_addr = AW'(mid);
    end else if (cmd_i.up_start) begin
      rd_addr = AW'(cnt_less);
    end else if (cmd_i.up_step) begin
      rd_addr = AW'(ptr_dec);
    end else if (cmd_i.dn_start) begin
      rd_addr = AW'(lo_inc);
    end else if (cmd_i.dn_step) begin
      rd_addr = AW'(ptr_inc);
    end

    wr_en   = cmd_i.up_step | cmd_i.dn_step | cmd_i.write_new;
    wr_addr = AW'(lo_q);
    wr_key  = key_q;
    wr_val  = val_q;
    if (cmd_i.up_step) begin
      wr_addr = AW'(ptr_inc);
      wr_key  = rd_key_q;
      wr_val  = rd_val_q;
    end else if (cmd_i.dn_step) begin
      wr_addr = AW'(ptr_dec);
      wr_key  = rd_key_q;
      wr_val  = rd_val_q;
    end
  end

  // Entry memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_val_q <= val_mem[rd_addr];
    end
  end

  // Operands, search window, shift pointer and working result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q   <= req_action_i;
      key_q   <= KEY_WIDTH'(req_key_i);
      val_q   <= req_value_i;
      hi_q    <= cnt_q;
      found_q <= 1'b0;
      kout_q  <= '0;
      vout_q  <= '0;
      status_q <= (req_action_i == ACT_CLEAR) ? STS_OK : STS_MISS;
      if (req_action_i inside {ACT_REM_IDX, ACT_READ_IDX}) begin
        lo_q  <= CNT_W'(req_index_i);
        pos_q <= POS_W'(req_index_i);
      end else begin
        lo_q  <= '0;
        pos_q <= '0;
      end
    end
    if (cmd_i.bs_update) begin
      if (rd_key_q < key_q) begin
        lo_q <= mid + 1'b1;
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.probe_capture) begin
      hit_q   <= hit;
      found_q <= hit;
      pos_q   <= POS_W'(lo_q);
      kout_q  <= hit ? DATA_W'(rd_key_q) : '0;
      vout_q  <= hit ? rd_val_q : '0;
    end
    if (cmd_i.idx_capture) begin
      kout_q <= DATA_W'(rd_key_q);
      vout_q <= rd_val_q;
    end
    if (cmd_i.clr_key) begin
      kout_q <= '0;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.up_start) begin
      ptr_q <= cnt_less;
    end else if (cmd_i.up_step) begin
      ptr_q <= ptr_dec;
    end else if (cmd_i.dn_start) begin
      ptr_q <= lo_inc;
    end else if (cmd_i.dn_step) begin
      ptr_q <= ptr_inc;
    end
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clear) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_less;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      o_status_q <= status_q;
      o_found_q  <= found_q;
      o_pos_q    <= pos_q;
      o_kout_q   <= kout_q;
      o_vout_q   <= vout_q;
      o_count_q  <= COUNT_W'(cnt_q);
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = o_status_q;
  assign rsp_o.found     = o_found_q;
  assign rsp_o.position  = o_pos_q;
  assign rsp_o.key_out   = o_kout_q;
  assign rsp_o.value_out = o_vout_q;
  assign rsp_o.count     = o_count_q;

  // The table never holds more entries than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The count only grows when a slot is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (cnt_q < CNT_W'(CAPACITY)))
    else $error("count increment on a full table");

  // Upward shifts stay inside the valid entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.up_step |-> (ptr_q < cnt_q) && (ptr_q >= lo_q))
    else $error("upward shift pointer out of range");

  // Downward shifts move entries between the removed slot and the top.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dn_step |-> (ptr_q > lo_q) && (ptr_q < cnt_q))
    else $error("downward shift pointer out of range");

endmodule

FILE: rtl/sorted_table_insert_search.sv
// Top level of the sorted key/value table: configuration register and the
// controller/datapath pair. Depends on sti_pkg, sti_if, sti_ctrl and sti_dpath.
//
//   Channel   Direction  Handshake            Carries
//   req_i     in         valid/ready          action, key, value, index
//   rsp_o     out        valid/ready          status, found, position, key_out,
//                                             value_out, count
//   APB       in/out     psel/penable/pready  allow_duplicates at word 0
//
// One request at a time: a new request is accepted only after the last result is loaded.
// Search-type actions halve the window until it is empty and probe the lower bound; insert
// then shifts the entries from the insertion point up, and a removal by key that hits shifts
// those above it down. Index actions in range read the slot, plus the removal shift; clear,
// bad indexes and unknown actions go to the result. Worst case: insert at position 0 of 255.
// A stalled response holds only the next result; reset empties the table at once.
module sorted_table_insert_search
  import sti_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sti_in_if.sink            req_i,
  sti_out_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic     allow_dup_q;
  logic     reg_sel;
  logic     ctrl_ready;
  sti_cmd_t cmd;
  sti_sts_t sts;

  // Configuration register access.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1:2] == REG_ALLOW_DUP);
  assign prdata  = reg_sel ? APB_DW'(allow_dup_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_dup_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      allow_dup_q <= pwdata[0];
    end
  end

  assign req_i.ready = ctrl_ready;

  // Sequencer.
  sti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (ctrl_ready),
    .allow_dup_i (allow_dup_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Entry storage and result datapath.
  sti_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_action_i (req_i.action),
    .req_key_i    (req_i.key),
    .req_value_i  (req_i.value),
    .req_index_i  (req_i.index),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_o        (rsp_o)
  );

endmodule
